FILE: hdl/fmrb_pkg.sv
// ----------------------------------------------------------------------------
// fmrb_pkg
// types and constants shared by the framed message ring buffer
// ----------------------------------------------------------------------------
package fmrb_pkg;

   localparam int TAG_BYTES = 6;

   typedef enum logic [2:0] {
      FUNC_PUT    = 3'd0,
      FUNC_SAVE   = 3'd1,
      FUNC_UNDO   = 3'd2,
      FUNC_REMOVE = 3'd3,
      FUNC_READ   = 3'd4
   } func_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  data_byte;
      logic [31:0] timestamp;
      logic [7:0]  target_index;
      logic [9:0]  read_offset;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_byte;
      logic        read_valid;
      logic        has_messages;
      logic [10:0] committed_bytes;
      logic [6:0]  open_bytes;
      logic [7:0]  last_seq;
      logic        removed_ok;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROOM,
      ST_APPEND,
      ST_SCAN_REQ,
      ST_SCAN_CHK,
      ST_READ_REQ,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic start_scan;
      logic scan_read;
      logic scan_step;
      logic append_step;
      logic put_char;
      logic undo;
      logic save_drop;
      logic read_issue;
      logic read_take;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_room;
      logic scan_end;
      logic scan_hit;
      logic append_last;
      logic open_full;
      logic open_empty;
      logic have_commit;
   } sts_type;

endpackage

FILE: hdl/fmrb_ctrl.sv
// ----------------------------------------------------------------------------
// fmrb_ctrl
// sequencing state machine for the framed message ring buffer
// ----------------------------------------------------------------------------
module fmrb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fmrb_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fmrb_pkg::cmd_type  cmd,
   input  fmrb_pkg::sts_type  sts
);

   fmrb_pkg::state_type state_ff, state_in;
   logic [2:0]          func_ff, func_in;
   logic                room_ff, room_in;
   logic                rsp_valid_ff, rsp_valid_in;

   wire accept = req_valid && !req_stall;

   assign req_stall = (state_ff != fmrb_pkg::ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmrb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;
      room_ff <= room_in;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      room_in      = room_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         fmrb_pkg::ST_IDLE: begin
            if (accept) begin
               func_in = req_data.func;
               room_in = 1'b0;
               case (req_data.func)
                  fmrb_pkg::FUNC_PUT: begin
                     if (req_data.data_byte != 8'd0 && sts.open_empty) begin
                        state_in = fmrb_pkg::ST_ROOM;
                        room_in  = 1'b1;
                     end else begin
                        state_in = fmrb_pkg::ST_DONE;
                     end
                  end
                  fmrb_pkg::FUNC_SAVE: begin
                     if (sts.open_full) begin
                        state_in = fmrb_pkg::ST_DONE;
                     end else if (sts.open_empty) begin
                        state_in = fmrb_pkg::ST_ROOM;
                        room_in  = 1'b1;
                     end else begin
                        state_in = fmrb_pkg::ST_APPEND;
                     end
                  end
                  fmrb_pkg::FUNC_REMOVE: begin
                     state_in = sts.have_commit ? fmrb_pkg::ST_SCAN_REQ :
                                                  fmrb_pkg::ST_DONE;
                  end
                  fmrb_pkg::FUNC_READ: state_in = fmrb_pkg::ST_READ_REQ;
                  default:             state_in = fmrb_pkg::ST_DONE;
               endcase
            end
         end
         fmrb_pkg::ST_ROOM: begin
            if (sts.need_room) begin
               state_in = fmrb_pkg::ST_SCAN_REQ;
            end else if (func_ff == fmrb_pkg::FUNC_SAVE) begin
               state_in = fmrb_pkg::ST_APPEND;
            end else begin
               state_in = fmrb_pkg::ST_DONE;
            end
         end
         fmrb_pkg::ST_SCAN_REQ: state_in = fmrb_pkg::ST_SCAN_CHK;
         fmrb_pkg::ST_SCAN_CHK: begin
            if (sts.scan_hit) begin
               state_in = room_ff ? fmrb_pkg::ST_ROOM : fmrb_pkg::ST_DONE;
            end else if (sts.scan_end) begin
               if (!room_ff) begin
                  state_in = fmrb_pkg::ST_DONE;
               end else if (func_ff == fmrb_pkg::FUNC_SAVE) begin
                  state_in = fmrb_pkg::ST_APPEND;
               end else begin
                  state_in = fmrb_pkg::ST_DONE;
               end
            end else begin
               state_in = fmrb_pkg::ST_SCAN_REQ;
            end
         end
         fmrb_pkg::ST_APPEND: begin
            if (sts.append_last) state_in = fmrb_pkg::ST_DONE;
         end
         fmrb_pkg::ST_READ_REQ:  state_in = fmrb_pkg::ST_READ_WAIT;
         fmrb_pkg::ST_READ_WAIT: state_in = fmrb_pkg::ST_DONE;
         fmrb_pkg::ST_DONE: begin
            state_in     = fmrb_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = fmrb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         fmrb_pkg::ST_IDLE: begin
            cmd.load_req = accept;
            if (accept) begin
               cmd.put_char  = (req_data.func == fmrb_pkg::FUNC_PUT) &&
                               (req_data.data_byte != 8'd0) && !sts.open_empty;
               cmd.undo      = (req_data.func == fmrb_pkg::FUNC_UNDO);
               cmd.save_drop = (req_data.func == fmrb_pkg::FUNC_SAVE) && sts.open_full;
            end
         end
         fmrb_pkg::ST_ROOM: begin
            cmd.start_scan = sts.need_room;
            cmd.put_char   = !sts.need_room && (func_ff == fmrb_pkg::FUNC_PUT);
         end
         fmrb_pkg::ST_SCAN_REQ: cmd.scan_read = 1'b1;
         fmrb_pkg::ST_SCAN_CHK: begin
            cmd.scan_step = 1'b1;
            cmd.put_char  = room_ff && sts.scan_end && !sts.scan_hit &&
                            (func_ff == fmrb_pkg::FUNC_PUT);
         end
         fmrb_pkg::ST_APPEND:    cmd.append_step = 1'b1;
         fmrb_pkg::ST_READ_REQ:  cmd.read_issue = 1'b1;
         fmrb_pkg::ST_READ_WAIT: cmd.read_take = 1'b1;
         default:                cmd = '0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == fmrb_pkg::ST_IDLE)
      else $error("result pending while busy");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == fmrb_pkg::ST_DONE |=> rsp_valid_ff)
      else $error("done without result");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == fmrb_pkg::ST_SCAN_REQ |=> state_ff == fmrb_pkg::ST_SCAN_CHK)
      else $error("scan sequencing broken");

endmodule

FILE: hdl/fmrb_datapath.sv
// ----------------------------------------------------------------------------
// fmrb_datapath
// byte store, pointers, counters and message scan for the ring buffer
// ----------------------------------------------------------------------------
module fmrb_datapath #(
   parameter int BUF_BYTES = 1024,
   parameter int MAX_TEXT  = 64,
   parameter int MAX_INDEX = 255
) (
   input  logic               clock,
   input  logic               reset,
   input  fmrb_pkg::req_type  req_data,
   input  fmrb_pkg::cmd_type  cmd,
   output fmrb_pkg::sts_type  sts,
   output fmrb_pkg::rsp_type  rsp_data
);

   localparam int AW = $clog2(BUF_BYTES);
   localparam int CW = $clog2(BUF_BYTES + 1);
   localparam int OW = $clog2(MAX_TEXT + fmrb_pkg::TAG_BYTES + 1);
   localparam int RW = (CW > 10) ? CW : 10;
   localparam logic [AW-1:0] LAST = AW'(BUF_BYTES - 1);
   localparam logic [CW-1:0] ROOM_LIMIT = CW'(BUF_BYTES - MAX_TEXT - fmrb_pkg::TAG_BYTES);

   logic [7:0] mem [BUF_BYTES];
   logic [7:0] rd_ff;

   logic [AW-1:0] head_ff, commit_ff, wr_ff, scan_h_ff, rd_addr;
   logic [CW-1:0] count_ff, scan_n_ff;
   logic [OW-1:0] open_ff;
   logic [7:0]    seq_ff, seq_inc;
   logic [1:0]    phase_ff;   // 0 text, 1 stamp, 2 index
   logic [2:0]    tcnt_ff, acnt_ff;
   fmrb_pkg::req_type rq_ff;
   logic [7:0]    rbyte_ff;
   logic          rvalid_ff, rem_ok_ff;
   logic          room_scan_ff;

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
      nxt = (p == LAST) ? '0 : p + 1'b1;
   endfunction

   // read address
   logic [AW:0] rsum;
   always_comb begin
      rsum = {1'b0, head_ff} + (AW+1)'(rq_ff.read_offset);
      if (rsum >= (AW+1)'(BUF_BYTES)) rsum = rsum - (AW+1)'(BUF_BYTES);
      rd_addr = cmd.read_issue ? rsum[AW-1:0] : scan_h_ff;
   end

   // append byte selection
   logic [7:0] abyte;
   always_comb begin
      seq_inc = (seq_ff + 8'd1 >= 8'(MAX_INDEX)) ? 8'd1 : seq_ff + 8'd1;
      case (acnt_ff)
         3'd0:    abyte = 8'd0;
         3'd1:    abyte = rq_ff.timestamp[31:24];
         3'd2:    abyte = rq_ff.timestamp[23:16];
         3'd3:    abyte = rq_ff.timestamp[15:8];
         3'd4:    abyte = rq_ff.timestamp[7:0];
         default: abyte = seq_inc;
      endcase
   end

   logic       do_write;
   logic [7:0] wbyte;
   assign do_write = cmd.append_step || (cmd.put_char && open_ff < OW'(MAX_TEXT));
   assign wbyte    = cmd.append_step ? abyte :
                     cmd.load_req    ? req_data.data_byte : rq_ff.data_byte;

   always_ff @(posedge clock) begin
      if (do_write) mem[wr_ff] <= wbyte;
      if (cmd.scan_read || cmd.read_issue) rd_ff <= mem[rd_addr];
   end

   // scan step: examine byte at scan_h_ff
   wire idx_hit = (rd_ff == rq_ff.target_index) || (rq_ff.target_index == 8'(MAX_INDEX)) ||
                  room_scan_ff;

   // combinational scan decision on the byte just fetched
   logic          s_hit, s_end;
   logic [AW-1:0] s_h;
   logic [CW-1:0] s_n;
   logic [1:0]    s_phase;
   logic [2:0]    s_t;
   always_comb begin
      s_hit = 1'b0; s_end = 1'b0;
      s_h = nxt(scan_h_ff); s_n = scan_n_ff - 1'b1;
      s_phase = phase_ff; s_t = tcnt_ff;
      if (scan_n_ff == '0) begin
         s_end = 1'b1; s_h = scan_h_ff; s_n = scan_n_ff;
      end else begin
         case (phase_ff)
            2'd0: if (rd_ff == 8'd0) begin s_phase = 2'd1; s_t = 3'd0; end
            2'd1: begin
               s_t = tcnt_ff + 3'd1;
               if (tcnt_ff == 3'd3) s_phase = 2'd2;
            end
            default: begin
               s_phase = 2'd0;
               s_hit = idx_hit;
            end
         endcase
         if (!s_hit && s_n == '0) s_end = 1'b1;
      end
   end

   assign sts.need_room   = (count_ff != '0) && (count_ff > ROOM_LIMIT);
   assign sts.scan_end    = s_end;
   assign sts.scan_hit    = s_hit;
   assign sts.append_last = (acnt_ff == 3'd5);
   assign sts.open_full   = (open_ff >= OW'(MAX_TEXT));
   assign sts.open_empty  = (open_ff == '0);
   assign sts.have_commit = (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         commit_ff <= '0;
         wr_ff     <= '0;
         count_ff  <= '0;
         open_ff   <= '0;
         seq_ff    <= '0;
      end else begin
         if (cmd.undo || cmd.save_drop) begin
            wr_ff   <= commit_ff;
            open_ff <= '0;
         end else if (cmd.append_step && acnt_ff == 3'd5) begin
            wr_ff     <= nxt(wr_ff);
            seq_ff    <= seq_inc;
            commit_ff <= nxt(wr_ff);
            count_ff  <= count_ff + CW'(open_ff) + 1'b1;
            open_ff   <= '0;
         end else if (do_write) begin
            wr_ff   <= nxt(wr_ff);
            open_ff <= open_ff + 1'b1;
         end
         if (cmd.scan_step && s_hit) begin
            head_ff  <= s_h;
            count_ff <= s_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rq_ff     <= req_data;
         rvalid_ff <= 1'b0;
         rbyte_ff  <= 8'd0;
         rem_ok_ff <= 1'b0;
         acnt_ff   <= 3'd0;
         room_scan_ff <= 1'b0;
      end
      if (cmd.append_step) acnt_ff <= acnt_ff + 3'd1;
      if (cmd.start_scan || (cmd.load_req && req_data.func == fmrb_pkg::FUNC_REMOVE)) begin
         scan_h_ff <= head_ff;
         scan_n_ff <= count_ff;
         phase_ff  <= 2'd0;
         tcnt_ff   <= 3'd0;
      end
      if (cmd.start_scan) room_scan_ff <= 1'b1;
      if (cmd.scan_step) begin
         scan_h_ff <= s_h;
         scan_n_ff <= s_n;
         phase_ff  <= s_phase;
         tcnt_ff   <= s_t;
         if (s_hit && !room_scan_ff) rem_ok_ff <= 1'b1;
      end
      if (cmd.read_take && (RW'(rq_ff.read_offset) < RW'(count_ff))) begin
         rvalid_ff <= 1'b1;
         rbyte_ff  <= rd_ff;
      end
   end

   always_comb begin
      rsp_data.read_byte       = rbyte_ff;
      rsp_data.read_valid      = rvalid_ff;
      rsp_data.has_messages    = (count_ff != '0);
      rsp_data.committed_bytes = 11'(count_ff);
      rsp_data.open_bytes      = 7'(open_ff);
      rsp_data.last_seq        = seq_ff;
      rsp_data.removed_ok      = rem_ok_ff;
   end

   assert property (@(posedge clock) disable iff (reset)
      open_ff <= OW'(MAX_TEXT + fmrb_pkg::TAG_BYTES))
      else $error("open count overrun");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(BUF_BYTES))
      else $error("committed count overrun");
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> scan_n_ff <= count_ff)
      else $error("scan beyond committed data");

endmodule

FILE: hdl/framed_message_ring_buffer.sv
// ----------------------------------------------------------------------------
// framed_message_ring_buffer
// byte ring buffer of framed log messages with put, save, undo, remove, read
// ----------------------------------------------------------------------------
// undo, a dropped save and a put into an open message go straight to the result; the
// first put of a message checks for room first; read fetches one stored byte; save appends
// terminator, stamp and index, after a room check if empty; eviction and remove scan stored bytes
// one item at a time; the next transfer is taken after the result leaves
// synchronous reset empties the buffer; store contents are left as they are
module framed_message_ring_buffer #(
   parameter int BUF_BYTES = 1024,
   parameter int MAX_TEXT  = 64,
   parameter int MAX_INDEX = 255
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fmrb_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fmrb_pkg::rsp_type  rsp_data
);

   fmrb_pkg::cmd_type cmd;
   fmrb_pkg::sts_type sts;

   fmrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   fmrb_datapath #(
      .BUF_BYTES (BUF_BYTES),
      .MAX_TEXT  (MAX_TEXT),
      .MAX_INDEX (MAX_INDEX)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
